// ----- rtl/rmvs_pkg.sv -----
// Shared constants and types for the running mean / variance statistics block.
// No dependencies.
`default_nettype none
package rmvs_pkg;
    localparam int unsigned COUNT_BITS_DEF = 20;
    localparam int unsigned SAMPLE_W       = 32;
    localparam int unsigned OUT_COUNT_W    = 20;
    localparam int unsigned DEV_W          = 31;
    localparam int unsigned SUM_W          = 64;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       update_variance;
    } t_in_item;

    typedef struct packed {
        logic [OUT_COUNT_W-1:0]     sample_count;
        logic signed [SAMPLE_W-1:0] running_mean;
        logic [DEV_W-1:0]           std_deviation;
        logic signed [SAMPLE_W-1:0] min_sample;
        logic signed [SAMPLE_W-1:0] max_sample;
    } t_out_item;
endpackage
`default_nettype wire

// ----- rtl/rmvs_if.sv -----
// Valid/ready channel interface carrying one payload beat.
// Depends on nothing; payload type is a parameter.
`default_nettype none
interface rmvs_if #(
    parameter type t_payload = logic
) (
    input wire i_clk
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/rmvs_front.sv -----
// Front end: accepts input beats into a two-entry queue for the back end.
// Depends on rmvs_pkg.
`default_nettype none
module rmvs_front
    import rmvs_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  wire       i_ready,
    output t_in_item  o_item
);
    t_in_item   r_q [2];
    logic       r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        n_wp  = w_push ? ~r_wp : r_wp;
        n_rp  = w_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (w_push) begin
            r_q[r_wp] <= i_item;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/rmvs_back.sv -----
// Back end: Welford update with a serial divider, multiplier and square root.
// Depends on rmvs_pkg.
`default_nettype none
module rmvs_back
    import rmvs_pkg::*;
#(
    parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_ready,
    input  t_in_item   i_item,
    output logic       o_valid,
    input  wire        i_ready,
    output t_out_item  o_item
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MDIV = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_VDIV = 3'd3;
    localparam logic [2:0] S_SQRT = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [2:0]              r_st;
    logic [COUNT_BITS-1:0]   r_cnt_all, r_cnt_var;
    logic signed [31:0]      r_mean, r_min, r_max, r_old_mean;
    logic [SUM_W-1:0]        r_sum;
    logic [DEV_W-1:0]        r_dev;
    logic signed [31:0]      r_smp;
    logic                    r_upd;
    logic                    r_neg;
    // shared restoring divider: dividend r_dq, remainder r_rem
    logic [SUM_W-1:0]        r_dq;
    logic [COUNT_BITS:0]     r_rem;
    logic [COUNT_BITS-1:0]   r_dvs;
    logic [6:0]              r_it;
    // multiplier partials (16-bit digit of a2 per step)
    logic [31:0]             r_a1, r_a2;
    logic [SUM_W:0]          r_prod;
    // square root
    logic [SUM_W-1:0]        r_x, r_root, r_bit;
    t_out_item               r_out;
    logic                    r_ov;

    logic [COUNT_BITS:0]     w_trial;
    logic signed [32:0]      w_d1, w_d2;
    logic [33:0]             w_q;
    logic [SUM_W-1:0]        w_rb;
    logic [47:0]             w_pp;

    assign o_ready = (r_st == S_IDLE) && !r_ov;
    assign o_valid = r_ov;
    assign o_item  = r_out;

    assign w_trial = {r_rem[COUNT_BITS-1:0], r_dq[SUM_W-1]};
    assign w_d1    = 33'(r_smp) - 33'(r_old_mean);
    assign w_d2    = 33'(r_smp) - 33'(r_mean);
    assign w_rb    = r_root + r_bit;
    assign w_q     = r_neg ? 34'(-$signed({1'b0, r_dq[32:0]}))
                           : {1'b0, r_dq[32:0]};
    assign w_pp    = r_a1 * r_a2[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= S_IDLE;
            r_ov      <= 1'b0;
            r_cnt_all <= '0;
            r_cnt_var <= '0;
            r_mean    <= '0;
            r_min     <= '0;
            r_max     <= '0;
            r_sum     <= '0;
            r_dev     <= '0;
        end else begin
            if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
            case (r_st)
                S_IDLE: begin
                    if (i_valid && !r_ov) begin
                        r_smp      <= i_item.sample;
                        r_upd      <= i_item.update_variance;
                        r_old_mean <= r_mean;
                        if (r_cnt_all == '0) begin
                            r_min <= i_item.sample;
                            r_max <= i_item.sample;
                        end else begin
                            if (i_item.sample < r_min) r_min <= i_item.sample;
                            if (i_item.sample > r_max) r_max <= i_item.sample;
                        end
                        if (r_cnt_all != CNT_MAX) begin
                            r_cnt_all <= r_cnt_all + 1'b1;
                            r_dvs     <= r_cnt_all + 1'b1;
                        end else begin
                            r_dvs <= r_cnt_all;
                        end
                        begin
                            logic signed [32:0] v_d;
                            v_d = 33'(i_item.sample) - 33'(r_mean);
                            r_neg <= v_d[32];
                            r_dq  <= {v_d[32] ? 33'(-v_d) : v_d, 31'd0};
                        end
                        r_rem <= '0;
                        r_it  <= 7'd33;
                        r_st  <= S_MDIV;
                    end
                end
                S_MDIV, S_VDIV: begin
                    if (w_trial >= {1'b0, r_dvs}) begin
                        r_rem <= w_trial - {1'b0, r_dvs};
                        r_dq  <= {r_dq[SUM_W-2:0], 1'b1};
                    end else begin
                        r_rem <= w_trial;
                        r_dq  <= {r_dq[SUM_W-2:0], 1'b0};
                    end
                    r_it <= r_it - 1'b1;
                    if (r_it == 7'd1) begin
                        r_st <= (r_st == S_MDIV) ? S_MUL : S_SQRT;
                        r_x    <= '0;
                        r_root <= '0;
                        r_bit  <= 64'd1 << 62;
                        r_it   <= 7'd0;
                    end
                end
                S_MUL: begin
                    if (r_it == 7'd0) begin
                        // quotient now in r_dq[32:0]; apply mean step
                        r_mean <= 32'($signed(r_mean) + $signed(w_q));
                        r_it   <= 7'd1;
                        if (!r_upd) begin
                            r_st <= S_OUT;
                        end
                    end else if (r_it == 7'd1) begin
                        r_a1   <= w_d1[32] ? 32'(-w_d1) : 32'(w_d1);
                        r_a2   <= w_d2[32] ? 32'(-w_d2) : 32'(w_d2);
                        r_prod <= '0;
                        r_it   <= 7'd2;
                    end else if (r_it < 7'd5) begin
                        r_prod <= r_prod + ({17'd0, w_pp} << (16 * (r_it - 7'd2)));
                        r_a2 <= r_a2 >> 16;
                        r_it <= r_it + 1'b1;
                    end else begin
                        logic [SUM_W:0]        v_s;
                        logic [COUNT_BITS-1:0] v_cv;
                        v_s  = {1'b0, r_sum} + r_prod;
                        v_cv = (r_cnt_var != CNT_MAX) ? r_cnt_var + 1'b1 : r_cnt_var;
                        r_cnt_var <= v_cv;
                        r_sum <= v_s[SUM_W] ? '1 : v_s[SUM_W-1:0];
                        if (v_cv < COUNT_BITS'(2)) begin
                            r_dev <= '0;
                            r_st  <= S_OUT;
                        end else begin
                            r_dvs <= v_cv - 1'b1;
                            r_dq  <= v_s[SUM_W] ? '1 : v_s[SUM_W-1:0];
                            r_rem <= '0;
                            r_it  <= 7'd64;
                            r_st  <= S_VDIV;
                        end
                    end
                end
                S_SQRT: begin
                    // first cycle loads the quotient, then two bits per step
                    if (r_it == 7'd0) begin
                        r_x  <= r_dq;
                        r_it <= 7'd1;
                    end else if (r_bit == '0) begin
                        r_dev <= (r_root > 64'h7FFF_FFFF) ? '1 : r_root[DEV_W-1:0];
                        r_st  <= S_OUT;
                    end else begin
                        if (r_x >= w_rb) begin
                            r_x    <= r_x - w_rb;
                            r_root <= (r_root >> 1) + r_bit;
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                end
                S_OUT: begin
                    r_out.sample_count  <= (COUNT_BITS > OUT_COUNT_W &&
                        (r_cnt_all >> OUT_COUNT_W) != '0) ? '1
                        : OUT_COUNT_W'(r_cnt_all);
                    r_out.running_mean  <= r_mean;
                    r_out.std_deviation <= r_dev;
                    r_out.min_sample    <= r_min;
                    r_out.max_sample    <= r_max;
                    r_ov <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- rtl/running_mean_variance_stats.sv -----
// Top level of the running mean / variance statistics block.
// Depends on rmvs_pkg, rmvs_if, rmvs_front and rmvs_back.
//
// Usage: s_in carries one beat per sample (sample, update_variance);
// m_out carries one beat per sample (count, mean, deviation, min, max).
// Both channels use valid/ready; a beat moves when both are high.
// A two-entry queue takes input beats while the back end works.
// Path from input beat to result: the 33-step mean divider; with the
// variance flag also the multiplier and, from the second flagged sample,
// the 64-step variance divider and square root. One item is worked at
// a time: the back end takes a sample only when idle with no result held.
// The result register holds its beat until taken; the back end stalls
// on a full result register and the queue then fills and drops ready.
// Reset clears counts, mean, extremes, sum and deviation to zero.
`default_nettype none
module running_mean_variance_stats
    import rmvs_pkg::*;
#(
    parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
    input wire i_clk,
    input wire i_rst_n,
    rmvs_if.sink   s_in,
    rmvs_if.source m_out
);
    logic     w_v, w_r;
    t_in_item w_item;
    t_out_item w_out;

    rmvs_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_in.valid), .o_ready(s_in.ready), .i_item(s_in.data),
        .o_valid(w_v), .i_ready(w_r), .o_item(w_item)
    );

    rmvs_back #(.COUNT_BITS(COUNT_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_v), .o_ready(w_r), .i_item(w_item),
        .o_valid(m_out.valid), .i_ready(m_out.ready), .o_item(w_out)
    );
    assign m_out.data = w_out;
endmodule
`default_nettype wire

// ----- rtl/rmvs_checker.sv -----
// Port-level checks for running_mean_variance_stats, bound to the top level.
// Depends on rmvs_pkg.
`default_nettype none
module rmvs_checker
    import rmvs_pkg::*;
(
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input t_out_item i_out
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out))
        else $error("result beat dropped while stalled");
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out.min_sample <= i_out.max_sample || !i_out_valid)
        else $error("min above max");
    a_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid || (i_out.running_mean >= i_out.min_sample &&
                         i_out.running_mean <= i_out.max_sample))
        else $error("mean outside extremes");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid || i_out.sample_count != '0)
        else $error("result with zero count");
endmodule

bind running_mean_variance_stats rmvs_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_out_valid(m_out.valid), .i_out_ready(m_out.ready), .i_out(m_out.data)
);
`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking bench for running_mean_variance_stats: Welford statistics over Q16.16 samples.
// Depends on rmvs_pkg, rmvs_if and running_mean_variance_stats from the RTL; predicts each result beat in place.
module tb;
    import rmvs_pkg::*;

    localparam int unsigned CNT_BITS   = 20;
    localparam int unsigned IDLE_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always #1 i_clk = ~i_clk;

    rmvs_if #(.t_payload(t_in_item))  s_in (.i_clk(i_clk));
    rmvs_if #(.t_payload(t_out_item)) m_out (.i_clk(i_clk));

    running_mean_variance_stats #(.COUNT_BITS(CNT_BITS)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .s_in   (s_in.sink),
        .m_out  (m_out.source)
    );

    // predictor state
    logic [CNT_BITS-1:0] n_all, n_var;
    logic signed [31:0]  mean_q, min_q, max_q;
    logic [63:0]         sqsum_q;
    logic [30:0]         dev_q;

    t_out_item stats_due[$];
    int        errors = 0;
    int        idle_cycles = 0;
    bit        sink_random = 1'b0;
    bit        sink_hold = 1'b0;
    bit        src_random = 1'b0;

    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= root + bitv) begin
                x    = x - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic t_out_item fold_sample(input t_in_item it);
        t_out_item r;
        logic signed [63:0] s, m_old, m_new, d1, d2;
        logic [63:0] a1, a2, prod, lim, root;
        lim = (64'd1 << CNT_BITS) - 1;
        s = it.sample;
        if (n_all == 0) begin
            min_q = it.sample;
            max_q = it.sample;
        end else begin
            if (it.sample < min_q) min_q = it.sample;
            if (it.sample > max_q) max_q = it.sample;
        end
        if (n_all < lim) n_all = n_all + 1;
        m_old = mean_q;
        m_new = m_old + (s - m_old) / $signed({44'd0, n_all});
        mean_q = m_new[31:0];
        if (it.update_variance) begin
            d1 = s - m_old;
            d2 = s - m_new;
            a1 = d1 < 0 ? -d1 : d1;
            a2 = d2 < 0 ? -d2 : d2;
            prod = a1 * a2;
            if (n_var < lim) n_var = n_var + 1;
            sqsum_q = (sqsum_q > ~64'd0 - prod) ? ~64'd0 : sqsum_q + prod;
            if (n_var < 2) begin
                dev_q = 0;
            end else begin
                root  = floor_sqrt(sqsum_q / (n_var - 1));
                dev_q = root > 64'h7FFFFFFF ? 31'h7FFFFFFF : root[30:0];
            end
        end
        r.sample_count  = n_all > 20'hFFFFF ? 20'hFFFFF : n_all;
        r.running_mean  = mean_q;
        r.std_deviation = dev_q;
        r.min_sample    = min_q;
        r.max_sample    = max_q;
        return r;
    endfunction

    // valid stays high after a beat; idling or draining drops it
    task automatic send_sample(input logic signed [31:0] smp, input bit upd);
        t_in_item it;
        it.sample = smp;
        it.update_variance = upd;
        while (src_random && $urandom_range(99) < 35) begin
            s_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        s_in.valid <= 1'b1;
        s_in.data  <= it;
        @(posedge i_clk);
        while (!s_in.ready) @(posedge i_clk);
        stats_due = {stats_due, fold_sample(it)};
    endtask

    task automatic wait_drained();
        s_in.valid <= 1'b0;
        while (stats_due.size() != 0) @(posedge i_clk);
    endtask

    // sink side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_out.ready <= 1'b0;
        end else begin
            m_out.ready <= !sink_hold && !(sink_random && $urandom_range(99) < 35);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out_item want, got;
        if (i_rst_n && m_out.valid && m_out.ready) begin
            got = m_out.data;
            if (stats_due.size() == 0) begin
                $display("%0t: result beat with nothing pending: %p", $time, got);
                errors++;
            end else begin
                want = stats_due.pop_front();
                if (got.sample_count !== want.sample_count) begin
                    $display("%0t: count exp %0d got %0d", $time,
                             want.sample_count, got.sample_count);
                    errors++;
                end
                if (got.running_mean !== want.running_mean) begin
                    $display("%0t: mean exp %h got %h", $time,
                             want.running_mean, got.running_mean);
                    errors++;
                end
                if (got.std_deviation !== want.std_deviation) begin
                    $display("%0t: deviation exp %h got %h", $time,
                             want.std_deviation, got.std_deviation);
                    errors++;
                end
                if (got.min_sample !== want.min_sample) begin
                    $display("%0t: min exp %h got %h", $time,
                             want.min_sample, got.min_sample);
                    errors++;
                end
                if (got.max_sample !== want.max_sample) begin
                    $display("%0t: max exp %h got %h", $time,
                             want.max_sample, got.max_sample);
                    errors++;
                end
            end
        end
    end

    // watchdog: count cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((s_in.valid && s_in.ready) || (m_out.valid && m_out.ready)) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("running_mean_variance_stats regression: fail");
                $finish;
            end
        end
    end

    function automatic logic signed [31:0] rand_sample();
        case ($urandom_range(5))
            0: rand_sample = $urandom;
            1: rand_sample = $urandom_range(1) ? 32'sh7FFFFFFF - $urandom_range(15)
                                               : 32'sh80000000 + $urandom_range(15);
            default: rand_sample = $signed($urandom_range(32'h00FFFFFF)) - 32'sh00800000;
        endcase
    endfunction

    task automatic test_directed();
        send_sample(32'sh00010000, 1'b1);  // first sample sets min and max
        send_sample(32'sh00010000, 1'b1);  // second variance sample, zero spread
        send_sample(32'sh7FFFFFFF, 1'b1);
        send_sample(32'sh80000000, 1'b1);
        send_sample(32'sh80000000, 1'b0);  // flag clear holds deviation
        send_sample(32'sh7FFFFFFF, 1'b0);
        send_sample(32'sh7FFFFFFF, 1'b1);
        send_sample(32'sh80000000, 1'b1);
        send_sample(32'sh00000000, 1'b1);
        send_sample(32'shFFFFFFFF, 1'b0);
        send_sample(32'sh00000001, 1'b1);
        send_sample(32'shAAAAAAAA, 1'b1);
        send_sample(32'sh55555555, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_smooth();
        repeat (150) send_sample(rand_sample(), $urandom_range(1));
    endtask

    task automatic test_random_idling();
        src_random  = 1'b1;
        sink_random = 1'b1;
        repeat (700) send_sample(rand_sample(), $urandom_range(3) != 0);
        // pause until drained, then carry on
        wait_drained();
        repeat (100) send_sample(rand_sample(), $urandom_range(1));
    endtask

    // hold the sink off long enough for the input queue to fill and stall
    task automatic test_backpressure();
        src_random = 1'b0;
        fork
            begin
                sink_hold = 1'b1;
                repeat (1500) @(posedge i_clk);
                sink_hold = 1'b0;
            end
            repeat (150) send_sample(rand_sample(), $urandom_range(1));
        join
    endtask

    initial begin
        s_in.valid  = 1'b0;
        s_in.data   = '0;
        n_all = 0; n_var = 0; mean_q = 0; min_q = 0; max_q = 0; sqsum_q = 0; dev_q = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_smooth();
        test_random_idling();
        test_backpressure();
        wait_drained();
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("running_mean_variance_stats regression: pass");
        end else begin
            $display("running_mean_variance_stats regression: fail");
        end
        $finish;
    end
endmodule
